>>> rtl/core/fpa_pkg.sv
package fpa_pkg;

   localparam int unsigned BLOCKS_DEFAULT      = 16;
   localparam int unsigned SIZE_BITS_DEFAULT   = 16;

   localparam int unsigned BLOCK_INDEX_W       = 4;
   localparam int unsigned AMOUNT_W            = 16;
   localparam int unsigned BLOCK_NUMBER_W      = 5;
   localparam int unsigned REMAINING_W         = 16;
   localparam int unsigned CSR_INDEX_W         = 1;
   localparam int unsigned CSR_DATA_W          = 5;
   localparam int unsigned BLOCKS_IN_USE_W     = 5;
   localparam int unsigned BLOCKS_IN_USE_RESET = 16;

   typedef enum logic [1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_NEXT  = 2'd2,
      FIT_WORST = 2'd3
   } strategy_type;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_ALLOC = 1'b1
   } operation_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STRATEGY      = 1'b0,
      CSR_BLOCKS_IN_USE = 1'b1
   } csr_index_type;

   // microprogram steps
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_INIT,
      ST_SCAN,
      ST_FINISH
   } step_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_START_ALLOC,
      COND_START_LOAD,
      COND_EMPTY,
      COND_SCAN_DONE
   } cond_sel_type;

   typedef struct packed {
      logic         idle;
      logic         do_load;
      logic         do_init;
      logic         do_scan;
      logic         do_finish;
      cond_sel_type cond_a;
      step_type     target_a;
      cond_sel_type cond_b;
      step_type     target_b;
      step_type     target_else;
   } ucode_type;

   typedef struct packed {
      logic start_alloc;
      logic start_load;
      logic empty;
      logic scan_done;
   } cond_type;

   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      w             = '0;
      w.cond_a      = COND_NEVER;
      w.cond_b      = COND_NEVER;
      w.target_a    = ST_IDLE;
      w.target_b    = ST_IDLE;
      w.target_else = ST_IDLE;
      unique case (step)
         ST_IDLE: begin
            w.idle     = 1'b1;
            w.cond_a   = COND_START_ALLOC;
            w.target_a = ST_INIT;
            w.cond_b   = COND_START_LOAD;
            w.target_b = ST_LOAD;
         end
         ST_LOAD: begin
            w.do_load = 1'b1;
         end
         ST_INIT: begin
            w.do_init     = 1'b1;
            w.cond_a      = COND_EMPTY;
            w.target_a    = ST_FINISH;
            w.target_else = ST_SCAN;
         end
         ST_SCAN: begin
            w.do_scan     = 1'b1;
            w.cond_a      = COND_SCAN_DONE;
            w.target_a    = ST_FINISH;
            w.target_else = ST_SCAN;
         end
         ST_FINISH: begin
            w.do_finish = 1'b1;
         end
         default: begin
            w.target_else = ST_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

>>> rtl/core/fpa_sequencer.sv
module fpa_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  fpa_pkg::cond_type   cond,
   output fpa_pkg::ucode_type  ctrl
);

   fpa_pkg::step_type step_ff;
   fpa_pkg::step_type step_in;
   logic              hit_a;
   logic              hit_b;

   function automatic logic cond_hit(input fpa_pkg::cond_sel_type sel,
                                     input fpa_pkg::cond_type c);
      logic hit;
      unique case (sel)
         fpa_pkg::COND_NEVER:       hit = 1'b0;
         fpa_pkg::COND_START_ALLOC: hit = c.start_alloc;
         fpa_pkg::COND_START_LOAD:  hit = c.start_load;
         fpa_pkg::COND_EMPTY:       hit = c.empty;
         fpa_pkg::COND_SCAN_DONE:   hit = c.scan_done;
         default:                   hit = 1'b0;
      endcase
      return hit;
   endfunction

   assign ctrl = fpa_pkg::ucode_rom(step_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= fpa_pkg::ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   // first jump wins, else fall to the default target
   always_comb begin
      hit_a   = cond_hit(ctrl.cond_a, cond);
      hit_b   = cond_hit(ctrl.cond_b, cond);
      step_in = ctrl.target_else;
      if (hit_a) begin
         step_in = ctrl.target_a;
      end else if (hit_b) begin
         step_in = ctrl.target_b;
      end
   end

endmodule

>>> rtl/core/fit_placement_allocator_top.sv
// Channel   Ports                                         Transfer
// -------   -------------------------------------------   -------------------------------
// request   start, busy, req_operation, req_block_index,  edge with start high, busy low
//           req_amount
// result    rsp_valid, rsp_granted, rsp_block_number,     every edge ending a rsp_valid cycle
//           rsp_remaining
// config    csr_write_enable, csr_index, csr_write_data   every edge with csr_write_enable high
//
// A load runs the load step and then returns to idle. An allocate runs a setup step, then
// the scan step of the microprogram, which reads the free-space memory one entry per cycle
// over at most the blocks in use, and then a finish step.
// First and next fit stop the scan at the first fitting block.
// The result strobe rises in the cycle after the last step and lasts one cycle; the receiver
// cannot stall it. Synchronous reset clears the sequencer, configuration and next-fit
// pointer; table contents are undefined until loaded.
module fit_placement_allocator_top #(
   parameter int unsigned BLOCKS    = fpa_pkg::BLOCKS_DEFAULT,
   parameter int unsigned SIZE_BITS = fpa_pkg::SIZE_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_operation,
   input  logic [fpa_pkg::BLOCK_INDEX_W-1:0]    req_block_index,
   input  logic [fpa_pkg::AMOUNT_W-1:0]         req_amount,
   output logic                                 rsp_valid,
   output logic                                 rsp_granted,
   output logic [fpa_pkg::BLOCK_NUMBER_W-1:0]   rsp_block_number,
   output logic [fpa_pkg::REMAINING_W-1:0]      rsp_remaining,
   input  logic                                 csr_write_enable,
   input  logic [fpa_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [fpa_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   localparam int unsigned IDX_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam int unsigned CNT_W = $clog2(BLOCKS + 1);

   fpa_pkg::ucode_type     ctrl;
   fpa_pkg::cond_type      cond;

   fpa_pkg::strategy_type  strategy_ff;
   logic [fpa_pkg::BLOCKS_IN_USE_W-1:0] blocks_in_use_ff;

   fpa_pkg::operation_type op_ff;
   logic [fpa_pkg::BLOCK_INDEX_W-1:0] idx_ff;
   logic [SIZE_BITS-1:0]   amt_ff;
   logic [CNT_W-1:0]       n_ff;
   logic [CNT_W-1:0]       n_active;

   logic [SIZE_BITS-1:0]   free_space [BLOCKS];
   logic [SIZE_BITS-1:0]   rd_data_ff;
   logic [IDX_W-1:0]       rd_addr;
   logic                   mem_we;
   logic [IDX_W-1:0]       mem_waddr;
   logic [SIZE_BITS-1:0]   mem_wdata;

   logic [IDX_W-1:0]       ptr_ff;
   logic [IDX_W-1:0]       k_ff;
   logic [CNT_W-1:0]       evl_ff;
   logic                   pick_vld_ff;
   logic [IDX_W-1:0]       pick_ff;
   logic [SIZE_BITS-1:0]   pick_val_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_granted_ff;
   logic [fpa_pkg::BLOCK_NUMBER_W-1:0] rsp_block_number_ff;
   logic [fpa_pkg::REMAINING_W-1:0]    rsp_remaining_ff;

   logic                   accept;
   logic                   load_ok;
   logic [IDX_W-1:0]       scan_start;
   logic [CNT_W-1:0]       k_plus;
   logic [IDX_W-1:0]       k_next;
   logic                   qual;
   logic                   better;
   logic                   take;
   logic [SIZE_BITS-1:0]   new_val;

   fpa_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .ctrl  (ctrl)
   );

   assign busy   = ~ctrl.idle;
   assign accept = start & ctrl.idle;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         strategy_ff      <= fpa_pkg::FIT_FIRST;
         blocks_in_use_ff <= fpa_pkg::BLOCKS_IN_USE_W'(fpa_pkg::BLOCKS_IN_USE_RESET);
      end else if (csr_write_enable) begin
         case (fpa_pkg::csr_index_type'(csr_index))
            fpa_pkg::CSR_STRATEGY:
               strategy_ff <= fpa_pkg::strategy_type'(csr_write_data[1:0]);
            fpa_pkg::CSR_BLOCKS_IN_USE:
               blocks_in_use_ff <= csr_write_data[fpa_pkg::BLOCKS_IN_USE_W-1:0];
            default: ;
         endcase
      end
   end

   // saturate blocks in use to the table depth
   assign n_active = (32'(blocks_in_use_ff) > BLOCKS) ? CNT_W'(BLOCKS)
                                                       : CNT_W'(blocks_in_use_ff);

   // hold the request for the length of the program
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= fpa_pkg::operation_type'(req_operation);
         idx_ff <= req_block_index;
         amt_ff <= SIZE_BITS'(req_amount);
         n_ff   <= n_active;
      end
   end

   assign load_ok    = 32'(idx_ff) < BLOCKS;
   assign scan_start = (strategy_ff == fpa_pkg::FIT_NEXT && CNT_W'(ptr_ff) < n_ff)
                       ? ptr_ff : '0;
   assign k_plus     = CNT_W'(k_ff) + CNT_W'(1);
   assign k_next     = (k_plus == n_ff) ? '0 : IDX_W'(k_plus);
   assign rd_addr    = ctrl.do_init ? scan_start : k_next;

   assign qual   = rd_data_ff >= amt_ff;
   assign better = ~pick_vld_ff
                   || (strategy_ff == fpa_pkg::FIT_BEST  && rd_data_ff < pick_val_ff)
                   || (strategy_ff == fpa_pkg::FIT_WORST && rd_data_ff > pick_val_ff);
   assign take   = ctrl.do_scan & qual & better;

   assign cond.start_alloc = start && fpa_pkg::operation_type'(req_operation) == fpa_pkg::OP_ALLOC;
   assign cond.start_load  = start && fpa_pkg::operation_type'(req_operation) == fpa_pkg::OP_LOAD;
   assign cond.empty       = n_ff == '0;
   assign cond.scan_done   = (evl_ff + CNT_W'(1) == n_ff)
                             || (qual && (strategy_ff == fpa_pkg::FIT_FIRST
                                          || strategy_ff == fpa_pkg::FIT_NEXT));

   assign new_val   = pick_val_ff - amt_ff;
   assign mem_we    = (ctrl.do_load & load_ok & (op_ff == fpa_pkg::OP_LOAD))
                      | (ctrl.do_finish & pick_vld_ff);
   assign mem_waddr = ctrl.do_load ? IDX_W'(idx_ff) : pick_ff;
   assign mem_wdata = ctrl.do_load ? amt_ff : new_val;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         free_space[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= free_space[rd_addr];
   end

   // scan bookkeeping: k_ff tags the entry now in rd_data_ff
   always_ff @(posedge clock) begin
      if (ctrl.do_init) begin
         k_ff   <= scan_start;
         evl_ff <= '0;
      end else if (ctrl.do_scan) begin
         k_ff   <= k_next;
         evl_ff <= evl_ff + CNT_W'(1);
      end
      if (take) begin
         pick_ff     <= k_ff;
         pick_val_ff <= rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pick_vld_ff <= 1'b0;
         ptr_ff      <= '0;
      end else begin
         if (ctrl.do_init) begin
            pick_vld_ff <= 1'b0;
         end else if (take) begin
            pick_vld_ff <= 1'b1;
         end
         if (ctrl.do_load && load_ok) begin
            ptr_ff <= '0;
         end else if (ctrl.do_finish && pick_vld_ff && strategy_ff == fpa_pkg::FIT_NEXT) begin
            ptr_ff <= pick_ff;
         end
      end
   end

   // result register: one-cycle strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl.do_load | ctrl.do_finish;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.do_load) begin
         rsp_granted_ff      <= 1'b0;
         rsp_block_number_ff <= '0;
         rsp_remaining_ff    <= load_ok ? fpa_pkg::REMAINING_W'(amt_ff) : '0;
      end else if (ctrl.do_finish) begin
         rsp_granted_ff      <= pick_vld_ff;
         rsp_block_number_ff <= pick_vld_ff
                                ? fpa_pkg::BLOCK_NUMBER_W'(32'(pick_ff) + 32'd1) : '0;
         rsp_remaining_ff    <= pick_vld_ff ? fpa_pkg::REMAINING_W'(new_val) : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_block_number = rsp_block_number_ff;
   assign rsp_remaining    = rsp_remaining_ff;

endmodule

>>> tb/sv/fit_placement_allocator_top_tb.sv
`timescale 1ns / 100ps
module fit_placement_allocator_top_tb;

   localparam int NUM_BLOCKS  = fpa_pkg::BLOCKS_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      fpa_pkg::operation_type             op;
      logic [fpa_pkg::BLOCK_INDEX_W-1:0]  idx;
      logic [fpa_pkg::AMOUNT_W-1:0]       amount;
   } request_type;

   typedef struct {
      logic                               granted;
      logic [fpa_pkg::BLOCK_NUMBER_W-1:0] number;
      logic [fpa_pkg::REMAINING_W-1:0]    remaining;
   } placement_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 start = 1'b0;
   logic                                 busy;
   logic                                 req_operation = 1'b0;
   logic [fpa_pkg::BLOCK_INDEX_W-1:0]    req_block_index = '0;
   logic [fpa_pkg::AMOUNT_W-1:0]         req_amount = '0;
   logic                                 rsp_valid;
   logic                                 rsp_granted;
   logic [fpa_pkg::BLOCK_NUMBER_W-1:0]   rsp_block_number;
   logic [fpa_pkg::REMAINING_W-1:0]      rsp_remaining;
   logic                                 csr_write_enable = 1'b0;
   logic [fpa_pkg::CSR_INDEX_W-1:0]      csr_index = '0;
   logic [fpa_pkg::CSR_DATA_W-1:0]       csr_write_data = '0;

   // predicted block state and configuration
   logic [fpa_pkg::AMOUNT_W-1:0]         space_model [NUM_BLOCKS];
   logic [fpa_pkg::BLOCK_INDEX_W-1:0]    next_fit_ptr = '0;
   fpa_pkg::strategy_type                fit_mode = fpa_pkg::FIT_FIRST;
   logic [fpa_pkg::BLOCKS_IN_USE_W-1:0]  blocks_cfg =
      fpa_pkg::BLOCKS_IN_USE_W'(fpa_pkg::BLOCKS_IN_USE_RESET);

   request_type                 request_queue[$];
   placement_type               placement_expected[$];
   request_type                 accepted_req;
   request_type                 next_req;
   placement_type               want;
   int unsigned                 sender_idle_pct = 0;
   int unsigned                 mismatch_count = 0;
   int unsigned                 cycle_count = 0;

   fit_placement_allocator_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_block_index  (req_block_index),
      .req_amount       (req_amount),
      .rsp_valid        (rsp_valid),
      .rsp_granted      (rsp_granted),
      .rsp_block_number (rsp_block_number),
      .rsp_remaining    (rsp_remaining),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int active_blocks();
      return (blocks_cfg > NUM_BLOCKS) ? NUM_BLOCKS : int'(blocks_cfg);
   endfunction

   // apply one request to the predicted table and return its placement
   function automatic placement_type place_request(request_type r);
      placement_type res;
      int n, pick, k, j;
      res = '{1'b0, '0, '0};
      n = active_blocks();
      pick = -1;
      if (r.op == fpa_pkg::OP_LOAD) begin
         space_model[r.idx] = r.amount;
         next_fit_ptr = '0;
         res.remaining = r.amount;
         return res;
      end
      if (fit_mode == fpa_pkg::FIT_NEXT) begin
         // circular scan; a pointer outside the blocks in use restarts at 0
         k = (next_fit_ptr < n) ? int'(next_fit_ptr) : 0;
         for (j = 0; j < n && pick < 0; j++) begin
            if (space_model[k] >= r.amount) pick = k;
            k = (k + 1 == n) ? 0 : k + 1;
         end
      end else begin
         for (j = 0; j < n; j++) begin
            if (space_model[j] >= r.amount) begin
               if (pick < 0 ||
                   (fit_mode == fpa_pkg::FIT_BEST && space_model[j] < space_model[pick]) ||
                   (fit_mode == fpa_pkg::FIT_WORST && space_model[j] > space_model[pick]))
                  pick = j;
            end
         end
      end
      if (pick >= 0) begin
         space_model[pick] = space_model[pick] - r.amount;
         if (fit_mode == fpa_pkg::FIT_NEXT) next_fit_ptr = fpa_pkg::BLOCK_INDEX_W'(pick);
         res.granted   = 1'b1;
         res.number    = fpa_pkg::BLOCK_NUMBER_W'(pick + 1);
         res.remaining = space_model[pick];
      end
      return res;
   endfunction

   // random request shaped around the current predicted table
   function automatic request_type random_request();
      request_type r;
      int n, blk, sel;
      n = active_blocks();
      if (n == 0) n = 1;
      blk = $urandom_range(0, n - 1);
      sel = $urandom_range(0, 99);
      r.idx = fpa_pkg::BLOCK_INDEX_W'($urandom_range(0, NUM_BLOCKS - 1));
      if (sel < 20) begin
         r.op = fpa_pkg::OP_LOAD;
         if ($urandom_range(0, 99) < 70) r.idx = fpa_pkg::BLOCK_INDEX_W'(blk);
         case ($urandom_range(0, 3))
            0: r.amount = fpa_pkg::AMOUNT_W'($urandom_range(0, 65535));
            1: r.amount = fpa_pkg::AMOUNT_W'($urandom_range(0, 1023));
            2: begin
               // few distinct sizes so that best and worst fit see ties
               case ($urandom_range(0, 2))
                  0: r.amount = 16'd64;
                  1: r.amount = 16'd1000;
                  default: r.amount = 16'd30000;
               endcase
            end
            default: r.amount = 16'hFFFF;
         endcase
      end else begin
         r.op = fpa_pkg::OP_ALLOC;
         sel = $urandom_range(0, 99);
         if (sel < 8)
            r.amount = '0;
         else if (sel < 18)
            r.amount = fpa_pkg::AMOUNT_W'($urandom_range(0, 65535));
         else if (sel < 43)
            r.amount = space_model[blk];
         else if (sel < 80)
            r.amount = fpa_pkg::AMOUNT_W'($urandom_range(0, space_model[blk]));
         else if (sel < 90)
            r.amount = 16'hFFFF;
         else
            r.amount = fpa_pkg::AMOUNT_W'($urandom_range(1, 64));
      end
      return r;
   endfunction

   // driver: one transfer per edge with start high and busy low
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            accepted_req.op     = fpa_pkg::operation_type'(req_operation);
            accepted_req.idx    = req_block_index;
            accepted_req.amount = req_amount;
            placement_expected.insert(placement_expected.size(),
                                      place_request(accepted_req));
         end
         if (!start || !busy) begin
            if (request_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               next_req = request_queue.pop_front();
               start           <= 1'b1;
               req_operation   <= next_req.op;
               req_block_index <= next_req.idx;
               req_amount      <= next_req.amount;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: results cannot be held off, check each strobe
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (placement_expected.size() == 0) begin
            $display("%0t: unexpected result granted=%0d block=%0d remaining=%0d",
                     $time, rsp_granted, rsp_block_number, rsp_remaining);
            mismatch_count++;
         end else begin
            want = placement_expected.pop_front();
            if (rsp_granted !== want.granted) begin
               $display("%0t: granted expected %0d got %0d", $time, want.granted, rsp_granted);
               mismatch_count++;
            end
            if (rsp_block_number !== want.number) begin
               $display("%0t: block_number expected %0d got %0d",
                        $time, want.number, rsp_block_number);
               mismatch_count++;
            end
            if (rsp_remaining !== want.remaining) begin
               $display("%0t: remaining expected %0d got %0d",
                        $time, want.remaining, rsp_remaining);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   task automatic queue_request(fpa_pkg::operation_type op, int idx, int amount);
      request_type r;
      r.op     = op;
      r.idx    = fpa_pkg::BLOCK_INDEX_W'(idx);
      r.amount = fpa_pkg::AMOUNT_W'(amount);
      request_queue.insert(request_queue.size(), r);
   endtask

   // hold the sender until every expected result is in, then let the block settle
   task automatic wait_drained();
      do @(negedge clock);
      while (request_queue.size() != 0 || start || placement_expected.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(fpa_pkg::csr_index_type idx,
                            logic [fpa_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      if (idx == fpa_pkg::CSR_STRATEGY)
         fit_mode = fpa_pkg::strategy_type'(data[1:0]);
      else
         blocks_cfg = data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic configure(fpa_pkg::strategy_type s, int n, int unsigned pct);
      wait_drained();
      write_csr(fpa_pkg::CSR_STRATEGY, fpa_pkg::CSR_DATA_W'(s));
      write_csr(fpa_pkg::CSR_BLOCKS_IN_USE, fpa_pkg::CSR_DATA_W'(n));
      @(negedge clock);
      sender_idle_pct = pct;
   endtask

   task automatic run_phase(fpa_pkg::strategy_type s, int n, int unsigned pct, int count);
      configure(s, n, pct);
      repeat (count) begin
         // keep the queue short so requests follow the current table
         while (request_queue.size() >= 2) @(negedge clock);
         request_queue.insert(request_queue.size(), random_request());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // fill the whole table before any allocate reads it
      queue_request(fpa_pkg::OP_LOAD, 0, 0);
      queue_request(fpa_pkg::OP_LOAD, 1, 65535);
      queue_request(fpa_pkg::OP_LOAD, 2, 100);
      queue_request(fpa_pkg::OP_LOAD, 3, 100);
      queue_request(fpa_pkg::OP_LOAD, 4, 50);
      queue_request(fpa_pkg::OP_LOAD, 5, 30000);
      queue_request(fpa_pkg::OP_LOAD, 6, 7);
      queue_request(fpa_pkg::OP_LOAD, 7, 100);
      queue_request(fpa_pkg::OP_LOAD, 8, 1);
      queue_request(fpa_pkg::OP_LOAD, 9, 65534);
      queue_request(fpa_pkg::OP_LOAD, 10, 2);
      queue_request(fpa_pkg::OP_LOAD, 11, 3);
      queue_request(fpa_pkg::OP_LOAD, 12, 4);
      queue_request(fpa_pkg::OP_LOAD, 13, 5);
      queue_request(fpa_pkg::OP_LOAD, 14, 6);
      queue_request(fpa_pkg::OP_LOAD, 15, 8);
      queue_request(fpa_pkg::OP_ALLOC, 15, 0);
      queue_request(fpa_pkg::OP_ALLOC, 0, 65535);
      queue_request(fpa_pkg::OP_ALLOC, 0, 65535);
      queue_request(fpa_pkg::OP_ALLOC, 0, 100);

      configure(fpa_pkg::FIT_BEST, 16, 0);
      queue_request(fpa_pkg::OP_ALLOC, 0, 100);
      configure(fpa_pkg::FIT_WORST, 16, 0);
      queue_request(fpa_pkg::OP_ALLOC, 0, 1);
      queue_request(fpa_pkg::OP_LOAD, 5, 65533);
      queue_request(fpa_pkg::OP_ALLOC, 0, 2);

      // park the next-fit pointer high, then shrink the blocks in use under it
      configure(fpa_pkg::FIT_NEXT, 16, 0);
      queue_request(fpa_pkg::OP_LOAD, 12, 65535);
      queue_request(fpa_pkg::OP_ALLOC, 0, 65000);
      queue_request(fpa_pkg::OP_ALLOC, 0, 0);
      configure(fpa_pkg::FIT_NEXT, 5, 0);
      queue_request(fpa_pkg::OP_ALLOC, 0, 0);
      configure(fpa_pkg::FIT_FIRST, 0, 0);
      queue_request(fpa_pkg::OP_ALLOC, 0, 0);
      configure(fpa_pkg::FIT_WORST, 17, 0);
      queue_request(fpa_pkg::OP_ALLOC, 0, 1);
      configure(fpa_pkg::FIT_BEST, 31, 0);
      queue_request(fpa_pkg::OP_ALLOC, 0, 1);

      run_phase(fpa_pkg::FIT_FIRST, 16, 0, 180);
      run_phase(fpa_pkg::FIT_BEST, 16, 62, 180);
      run_phase(fpa_pkg::FIT_NEXT, 16, 26, 180);
      run_phase(fpa_pkg::FIT_WORST, 16, 0, 180);
      run_phase(fpa_pkg::FIT_NEXT, 1, 62, 100);
      run_phase(fpa_pkg::FIT_BEST, 2, 26, 100);
      run_phase(fpa_pkg::FIT_FIRST, 31, 0, 120);
      run_phase(fpa_pkg::FIT_WORST, 9, 62, 120);
      run_phase(fpa_pkg::FIT_NEXT, 7, 0, 150);
      run_phase(fpa_pkg::FIT_FIRST, 0, 26, 40);
      run_phase(fpa_pkg::FIT_BEST, 20, 62, 130);
      run_phase(fpa_pkg::FIT_NEXT, 16, 26, 120);

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && placement_expected.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/fpa_pkg.sv
rtl/core/fpa_sequencer.sv
rtl/core/fit_placement_allocator_top.sv
tb/sv/fit_placement_allocator_top_tb.sv
